// File: rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks (the allocator core).
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ERLA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("erla assertion failed");

// next-cycle implication, off while reset is high
`define ERLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("erla assertion failed");

`endif

// File: rtl/erla_pkg.sv
// Shared types and codes for the extent run-list allocator.
// No dependencies.
`default_nettype none

package erla_pkg;

   localparam int CFG_W  = 21;
   localparam int SPAN_W = 21;
   localparam int OP_W   = 2;
   localparam int ST_W   = 3;

   localparam logic [CFG_W-1:0] BUF_SIZE_RESET = 21'h100000;

   localparam logic [OP_W-1:0] OP_FIND  = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   localparam logic [ST_W-1:0] ST_OK    = 3'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 3'd1;
   localparam logic [ST_W-1:0] ST_KIND  = 3'd2;
   localparam logic [ST_W-1:0] ST_SPAN  = 3'd3;
   localparam logic [ST_W-1:0] ST_FULL  = 3'd4;

   typedef struct packed {
      logic load;
      logic scan;
      logic eval;
      logic plan;
      logic move;
      logic wr0;
      logic wr1;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic edit;
      logic move_done;
   } sts_type;

endpackage

`default_nettype wire

// File: rtl/erla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module erla_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/erla_ctrl.sv
// Sequencer for the run-list allocator: scan, evaluate, shift, write, respond.
// Depends on erla_pkg.
`default_nettype none

module erla_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire erla_pkg::sts_type sts,
   output erla_pkg::cmd_type     cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_PLAN = 3'd3;
   localparam logic [2:0] S_MOVE = 3'd4;
   localparam logic [2:0] S_WR0  = 3'd5;
   localparam logic [2:0] S_WR1  = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_PLAN;
         end
         S_PLAN: begin
            cmd.plan = 1'b1;
            state_in = sts.edit ? S_MOVE : S_FIN;
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            if (sts.move_done) begin
               state_in = S_WR0;
            end
         end
         S_WR0: begin
            cmd.wr0  = 1'b1;
            state_in = S_WR1;
         end
         S_WR1: begin
            cmd.wr1  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/erla_dp.sv
// Datapath: run-start table, scan, split/merge planning, entry shifting, result.
// Depends on erla_pkg and erla_ram.
`default_nettype none

module erla_dp #(
   parameter int MAX_RUNS    = 64,
   parameter int OFFSET_BITS = 20
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire erla_pkg::cmd_type                  cmd,
   output erla_pkg::sts_type                       sts,
   input  wire logic [erla_pkg::OP_W-1:0]          req_opcode,
   input  wire logic [OFFSET_BITS-1:0]             req_offset,
   input  wire logic [erla_pkg::SPAN_W-1:0]        req_span_size,
   input  wire logic                               csr_we,
   input  wire logic [erla_pkg::CFG_W-1:0]         csr_wdata,
   output logic                                    rsp_strobe,
   output logic      [erla_pkg::ST_W-1:0]          rsp_status,
   output logic      [$clog2(MAX_RUNS)-1:0]        rsp_run_index,
   output logic      [OFFSET_BITS-1:0]             rsp_run_start,
   output logic                                    rsp_run_is_gap,
   output logic      [$clog2(MAX_RUNS+1)-1:0]      rsp_run_total
);

   localparam int IW = $clog2(MAX_RUNS);
   localparam int CW = $clog2(MAX_RUNS + 1);
   localparam int NW = $clog2(MAX_RUNS + 3);
   localparam int W  = ((OFFSET_BITS > erla_pkg::CFG_W) ? OFFSET_BITS : erla_pkg::CFG_W) + 2;
   localparam logic [W-1:0] OFF_LIM = {{(W-1){1'b0}}, 1'b1} << OFFSET_BITS;

   // configuration and table control
   logic [erla_pkg::CFG_W-1:0] bufsz_ff, bufsz_in;
   logic [CW-1:0]              count_ff, count_in;
   logic                       gap0_ff, gap0_in;

   // current item
   logic [erla_pkg::OP_W-1:0]   op_ff, op_in;
   logic [OFFSET_BITS-1:0]      off_ff, off_in;
   logic [erla_pkg::SPAN_W-1:0] size_ff, size_in;

   // scan results
   logic [CW-1:0]          sk_ff, sk_in;
   logic                   found_ff, found_in;
   logic                   rv_ff, rv_in;
   logic [IW-1:0]          rk_ff, rk_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [OFFSET_BITS-1:0] s_ff, s_in;
   logic [OFFSET_BITS-1:0] prev_ff, prev_in;
   logic [W-1:0]           end_ff, end_in;

   // edit plan
   logic [erla_pkg::ST_W-1:0] status_ff, status_in;
   logic                      edit_ff, edit_in;
   logic                      a_ff, a_in;
   logic [NW-1:0]             p_ff, p_in;
   logic [NW-1:0]             q_ff, q_in;
   logic [1:0]                vn_ff, vn_in;
   logic [NW-1:0]             nc_ff, nc_in;
   logic [OFFSET_BITS-1:0]    b_ff, b_in;

   // shift
   logic          up_ff, up_in;
   logic [1:0]    mag_ff, mag_in;
   logic [CW-1:0] left_ff, left_in;
   logic [NW-1:0] mk_ff, mk_in;

   // response
   logic                      strobe_ff, strobe_in;
   logic [erla_pkg::ST_W-1:0] r_status_ff, r_status_in;
   logic [IW-1:0]             r_index_ff, r_index_in;
   logic [OFFSET_BITS-1:0]    r_start_ff, r_start_in;
   logic                      r_gap_ff, r_gap_in;
   logic [CW-1:0]             r_total_ff, r_total_in;

   // RAM port
   logic                   ram_we;
   logic [IW-1:0]          ram_waddr;
   logic [OFFSET_BITS-1:0] ram_wdata;
   logic [IW-1:0]          ram_raddr;
   logic [OFFSET_BITS-1:0] ram_rdata;

   // shared combinational terms
   logic [W-1:0]  eff_w, off_w, b_w, lim_w;
   logic          kind, want, oor;
   logic          a_c, bl_c, nxt_c, rm_c, lm_c;
   logic [NW-1:0] nc_c, sum_c, wa_c;

   erla_ram #(
      .WIDTH(OFFSET_BITS),
      .DEPTH(MAX_RUNS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_comb begin
      eff_w = (W'(bufsz_ff) >= OFF_LIM) ? OFF_LIM : W'(bufsz_ff);
      off_w = W'(off_ff);
      b_w   = off_w + W'(size_ff);
      lim_w = (end_ff < eff_w) ? end_ff : eff_w;
      oor   = (off_w >= eff_w);
      kind  = gap0_ff ^ idx_ff[0];
      want  = (op_ff == erla_pkg::OP_FREE);
      a_c   = (off_ff > s_ff);
      bl_c  = (b_w < end_ff);
      nxt_c = ((NW'(idx_ff) + NW'(1)) < NW'(count_ff));
      rm_c  = !bl_c && nxt_c;
      lm_c  = !a_c && (idx_ff != '0);
      nc_c  = NW'(count_ff) + NW'(a_c) + NW'(bl_c) - NW'(lm_c) - NW'(rm_c);
      sum_c = p_ff + NW'(vn_ff);
      wa_c  = up_ff ? (NW'(rk_ff) + NW'(mag_ff)) : (NW'(rk_ff) - NW'(mag_ff));
   end

   always_comb begin
      bufsz_in    = csr_we ? csr_wdata : bufsz_ff;
      count_in    = count_ff;
      gap0_in     = gap0_ff;
      op_in       = op_ff;
      off_in      = off_ff;
      size_in     = size_ff;
      sk_in       = sk_ff;
      found_in    = found_ff;
      rv_in       = 1'b0;
      rk_in       = rk_ff;
      idx_in      = idx_ff;
      s_in        = s_ff;
      prev_in     = prev_ff;
      end_in      = end_ff;
      status_in   = status_ff;
      edit_in     = edit_ff;
      a_in        = a_ff;
      p_in        = p_ff;
      q_in        = q_ff;
      vn_in       = vn_ff;
      nc_in       = nc_ff;
      b_in        = b_ff;
      up_in       = up_ff;
      mag_in      = mag_ff;
      left_in     = left_ff;
      mk_in       = mk_ff;
      strobe_in   = cmd.fin;
      r_status_in = r_status_ff;
      r_index_in  = r_index_ff;
      r_start_in  = r_start_ff;
      r_gap_in    = r_gap_ff;
      r_total_in  = r_total_ff;
      ram_we      = 1'b0;
      ram_waddr   = '0;
      ram_wdata   = '0;
      ram_raddr   = '0;

      if (cmd.load) begin
         op_in    = req_opcode;
         off_in   = req_offset;
         size_in  = req_span_size;
         sk_in    = CW'(1);
         found_in = 1'b0;
         idx_in   = '0;
         s_in     = '0;
         prev_in  = '0;
      end

      if (cmd.scan) begin
         if (!found_ff && (sk_ff < count_ff)) begin
            ram_raddr = sk_ff[IW-1:0];
            rv_in     = 1'b1;
            rk_in     = sk_ff[IW-1:0];
            sk_in     = sk_ff + CW'(1);
         end
         if (rv_ff && !found_ff) begin
            if (ram_rdata <= off_ff) begin
               idx_in  = rk_ff;
               prev_in = s_ff;
               s_in    = ram_rdata;
            end else begin
               end_in   = W'(ram_rdata);
               found_in = 1'b1;
            end
         end else if (!found_ff && (sk_ff == count_ff)) begin
            end_in   = eff_w;
            found_in = 1'b1;
         end
      end

      if (cmd.eval) begin
         a_in    = a_c;
         nc_in   = nc_c;
         p_in    = (a_c || (idx_ff == '0)) ? (NW'(idx_ff) + NW'(1)) : NW'(idx_ff);
         q_in    = NW'(idx_ff) + NW'(1) + NW'(rm_c);
         vn_in   = {1'b0, a_c} + {1'b0, bl_c};
         b_in    = b_w[OFFSET_BITS-1:0];
         edit_in = 1'b0;
         if (op_ff == erla_pkg::OP_CLEAR) begin
            status_in = erla_pkg::ST_OK;
         end else if (oor) begin
            status_in = erla_pkg::ST_RANGE;
         end else if (op_ff == erla_pkg::OP_FIND) begin
            status_in = erla_pkg::ST_OK;
         end else if (kind == want) begin
            status_in = erla_pkg::ST_KIND;
         end else if (b_w > lim_w) begin
            status_in = erla_pkg::ST_SPAN;
         end else if (size_ff == '0) begin
            status_in = erla_pkg::ST_OK;
         end else if (nc_c > NW'(MAX_RUNS)) begin
            status_in = erla_pkg::ST_FULL;
         end else begin
            status_in = erla_pkg::ST_OK;
            edit_in   = 1'b1;
         end
      end

      if (cmd.plan) begin
         up_in  = (sum_c > q_ff);
         mag_in = (sum_c > q_ff) ? 2'(sum_c - q_ff) : 2'(q_ff - sum_c);
         if ((sum_c == q_ff) || (q_ff >= NW'(count_ff))) begin
            left_in = '0;
         end else begin
            left_in = CW'(NW'(count_ff) - q_ff);
         end
         mk_in = (sum_c > q_ff) ? (NW'(count_ff) - NW'(1)) : q_ff;
      end

      if (cmd.move) begin
         if (left_ff != '0) begin
            ram_raddr = mk_ff[IW-1:0];
            rv_in     = 1'b1;
            rk_in     = mk_ff[IW-1:0];
            mk_in     = up_ff ? (mk_ff - NW'(1)) : (mk_ff + NW'(1));
            left_in   = left_ff - CW'(1);
         end
         if (rv_ff) begin
            ram_we    = 1'b1;
            ram_waddr = wa_c[IW-1:0];
            ram_wdata = ram_rdata;
         end
      end

      if (cmd.wr0) begin
         ram_we    = (vn_ff != 2'd0);
         ram_waddr = p_ff[IW-1:0];
         ram_wdata = a_ff ? off_ff : b_ff;
      end

      if (cmd.wr1) begin
         ram_we    = (vn_ff == 2'd2);
         ram_waddr = IW'(p_ff + NW'(1));
         ram_wdata = b_ff;
      end

      if (cmd.fin) begin
         r_status_in = status_ff;
         if (op_ff == erla_pkg::OP_CLEAR) begin
            r_index_in = '0;
            r_start_in = '0;
            r_gap_in   = 1'b1;
            r_total_in = CW'(1);
            count_in   = CW'(1);
            gap0_in    = 1'b1;
         end else if (status_ff == erla_pkg::ST_RANGE) begin
            r_index_in = '0;
            r_start_in = '0;
            r_gap_in   = 1'b0;
            r_total_in = count_ff;
         end else if (edit_ff) begin
            if (a_ff) begin
               r_index_in = idx_ff + IW'(1);
               r_start_in = off_ff;
            end else if (idx_ff != '0) begin
               r_index_in = idx_ff - IW'(1);
               r_start_in = prev_ff;
            end else begin
               r_index_in = '0;
               r_start_in = '0;
               gap0_in    = want;
            end
            r_gap_in   = want;
            r_total_in = CW'(nc_ff);
            count_in   = CW'(nc_ff);
         end else begin
            r_index_in = idx_ff;
            r_start_in = s_ff;
            r_gap_in   = kind;
            r_total_in = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bufsz_ff  <= erla_pkg::BUF_SIZE_RESET;
         count_ff  <= CW'(1);
         gap0_ff   <= 1'b1;
         found_ff  <= 1'b0;
         rv_ff     <= 1'b0;
         edit_ff   <= 1'b0;
         left_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         bufsz_ff  <= bufsz_in;
         count_ff  <= count_in;
         gap0_ff   <= gap0_in;
         found_ff  <= found_in;
         rv_ff     <= rv_in;
         edit_ff   <= edit_in;
         left_ff   <= left_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      off_ff      <= off_in;
      size_ff     <= size_in;
      sk_ff       <= sk_in;
      rk_ff       <= rk_in;
      idx_ff      <= idx_in;
      s_ff        <= s_in;
      prev_ff     <= prev_in;
      end_ff      <= end_in;
      status_ff   <= status_in;
      a_ff        <= a_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      vn_ff       <= vn_in;
      nc_ff       <= nc_in;
      b_ff        <= b_in;
      up_ff       <= up_in;
      mag_ff      <= mag_in;
      mk_ff       <= mk_in;
      r_status_ff <= r_status_in;
      r_index_ff  <= r_index_in;
      r_start_ff  <= r_start_in;
      r_gap_ff    <= r_gap_in;
      r_total_ff  <= r_total_in;
   end

   always_comb begin
      sts.scan_done = found_ff;
      sts.edit      = edit_ff;
      sts.move_done = (left_ff == '0) && !rv_ff;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = r_status_ff;
   assign rsp_run_index  = r_index_ff;
   assign rsp_run_start  = r_start_ff;
   assign rsp_run_is_gap = r_gap_ff;
   assign rsp_run_total  = r_total_ff;

endmodule

`default_nettype wire

// File: rtl/extent_run_list_allocator_core.sv
// Flow: load, table scan, evaluate, plan, then the finish state and a registered strobe for find,
// clear and rejected operations; allocate/free also pass through the entry shift and the WR0/WR1 writes.
// One operation at a time; busy while working.
// The table scan and the entry shift both go through the single read port of the RAM.
// Synchronous reset: one gap run, buffer_size 1048576. Results cannot be stalled.
`default_nettype none
`include "assert_macros.svh"

module extent_run_list_allocator_core #(
   parameter int MAX_RUNS    = 64,
   parameter int OFFSET_BITS = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [erla_pkg::OP_W-1:0]     req_opcode,
   input  wire logic [OFFSET_BITS-1:0]        req_offset,
   input  wire logic [erla_pkg::SPAN_W-1:0]   req_span_size,
   input  wire logic                          csr_we,
   input  wire logic [erla_pkg::CFG_W-1:0]    csr_wdata,
   output logic                               rsp_strobe,
   output logic      [erla_pkg::ST_W-1:0]     rsp_status,
   output logic      [$clog2(MAX_RUNS)-1:0]   rsp_run_index,
   output logic      [OFFSET_BITS-1:0]        rsp_run_start,
   output logic                               rsp_run_is_gap,
   output logic      [$clog2(MAX_RUNS+1)-1:0] rsp_run_total
);

   erla_pkg::cmd_type cmd;
   erla_pkg::sts_type sts;

   erla_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .sts  (sts),
      .cmd  (cmd)
   );

   erla_dp #(
      .MAX_RUNS   (MAX_RUNS),
      .OFFSET_BITS(OFFSET_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_opcode    (req_opcode),
      .req_offset    (req_offset),
      .req_span_size (req_span_size),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_run_index (rsp_run_index),
      .rsp_run_start (rsp_run_start),
      .rsp_run_is_gap(rsp_run_is_gap),
      .rsp_run_total (rsp_run_total)
   );

   `ERLA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ERLA_ASSERT_IMPL(a_strobe_after_work, clock, reset, rsp_strobe, $past(busy))
   `ERLA_ASSERT_IMPL(a_total_nonzero, clock, reset, rsp_strobe, rsp_run_total != '0)

endmodule

`default_nettype wire
